FILE: rtl/mpb_pkg.sv
// ----------------------------------------------------------------------------
// mpb_pkg
// Shared types, codes, constants and helper functions of the memory pattern
// BIST sequencer.
// ----------------------------------------------------------------------------
package mpb_pkg;

    localparam longint unsigned C_MEM_BYTES = 64'd1048576;
    localparam int unsigned     C_ADDR_W    = 20;
    localparam int unsigned     C_DATA_W    = 64;
    localparam int unsigned     C_CFG_IDX_W = 4;
    localparam int unsigned     C_CFG_DAT_W = 8;
    localparam longint unsigned C_MAX_WORDS = 64'h100000;

    localparam logic [31:0] C_SEED     = 32'h7FFF_FFFF;
    localparam logic [31:0] C_TAP      = 32'h0000_00C5;
    localparam int unsigned C_DRAW_LEN = 33;
    localparam logic [3:0]  C_PAT_LAST = 4'hF;

    // result commands
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_PASS  = 3'd2;
    localparam logic [2:0] CMD_FAIL  = 3'd3;
    localparam logic [2:0] CMD_IDLE  = 3'd4;

    // test status
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PASS = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // phases
    localparam logic [1:0] PH_ADDR  = 2'd0;
    localparam logic [1:0] PH_SOLID = 2'd1;
    localparam logic [1:0] PH_RAND  = 2'd2;

    // width modes
    localparam logic [1:0] MODE_W8  = 2'd0;
    localparam logic [1:0] MODE_W16 = 2'd1;
    localparam logic [1:0] MODE_W32 = 2'd2;
    localparam logic [1:0] MODE_W64 = 2'd3;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] REG_WIDTH_MODE  = 4'd0;
    localparam logic [C_CFG_IDX_W-1:0] REG_READ_PASSES = 4'd1;

    localparam logic [1:0] C_MODE_RST   = MODE_W64;
    localparam logic [3:0] C_PASSES_RST = 4'd4;

    typedef logic [31:0][31:0] t_mat;
    typedef logic [3:0][20:0]  t_words;

    typedef struct packed {
        logic [1:0] word_width_mode;
        logic [3:0] read_passes;
    } t_cfg;

    typedef struct packed {
        logic [31:0]         lfsr;
        logic [1:0]          phase;
        logic [3:0]          pat_idx;
        logic [3:0]          pass_cnt;
        logic [C_ADDR_W-1:0] word_cnt;
        logic [C_DATA_W-1:0] expected;
        logic                pending;
        logic [1:0]          status;
    } t_state;

    typedef struct packed {
        logic [2:0]          command;
        logic [C_ADDR_W-1:0] word_address;
        logic [C_DATA_W-1:0] write_data;
        logic [1:0]          test_phase;
    } t_result;

    function automatic logic [31:0] f_lfsr_step(input logic [31:0] a);
        logic [31:0] r;
        r = {a[30:0], 1'b0};
        if (a[31]) begin
            r = r ^ C_TAP;
        end
        return r;
    endfunction

    // column j holds the image of bit j after n generator steps
    function automatic t_mat f_draw_mat(input int unsigned n);
        t_mat        m;
        logic [31:0] v;
        for (int j = 0; j < 32; j++) begin
            v = 32'd1 << j;
            for (int k = 0; k < n; k++) begin
                v = f_lfsr_step(v);
            end
            m[j] = v;
        end
        return m;
    endfunction

    function automatic logic [31:0] f_mat_mul(input t_mat m, input logic [31:0] a);
        logic [31:0] r;
        r = '0;
        for (int j = 0; j < 32; j++) begin
            if (a[j]) begin
                r = r ^ m[j];
            end
        end
        return r;
    endfunction

    function automatic logic [20:0] f_words(input int unsigned sh);
        longint unsigned w;
        w = C_MEM_BYTES >> sh;
        if (w > C_MAX_WORDS) begin
            w = C_MAX_WORDS;
        end
        if (w == 0) begin
            w = 1;
        end
        return w[20:0];
    endfunction

    function automatic logic [C_DATA_W-1:0] f_pattern(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h0;
            4'd1:    nib = 4'hF;
            4'd2:    nib = 4'h5;
            4'd3:    nib = 4'hA;
            4'd4:    nib = 4'h1;
            4'd5:    nib = 4'h2;
            4'd6:    nib = 4'h4;
            4'd7:    nib = 4'h8;
            4'd8:    nib = 4'h3;
            4'd9:    nib = 4'h6;
            4'd10:   nib = 4'h9;
            4'd11:   nib = 4'hC;
            4'd12:   nib = 4'h7;
            4'd13:   nib = 4'hB;
            4'd14:   nib = 4'hD;
            default: nib = 4'hE;
        endcase
        return {16{nib}};
    endfunction

    function automatic logic [C_DATA_W-1:0] f_mask(input logic [1:0] mode);
        logic [C_DATA_W-1:0] m;
        case (mode)
            MODE_W8:  m = 64'h0000_0000_0000_00FF;
            MODE_W16: m = 64'h0000_0000_0000_FFFF;
            MODE_W32: m = 64'h0000_0000_FFFF_FFFF;
            default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/mpb_intf.sv
// ----------------------------------------------------------------------------
// mpb interfaces
// Valid/ready channels of the sequencer: step input, command output and
// configuration write.
// ----------------------------------------------------------------------------
interface mpb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mpb_pkg::C_DATA_W-1:0]  read_data;

    modport source (output valid, output func, output read_data, input ready);
    modport sink   (input valid, input func, input read_data, output ready);
endinterface

interface mpb_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    command;
    logic [mpb_pkg::C_ADDR_W-1:0]  word_address;
    logic [mpb_pkg::C_DATA_W-1:0]  write_data;
    logic [1:0]                    test_phase;

    modport source (output valid, output command, output word_address,
                    output write_data, output test_phase, input ready);
    modport sink   (input valid, input command, input word_address,
                    input write_data, input test_phase, output ready);
endinterface

interface mpb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mpb_pkg::C_CFG_IDX_W-1:0] index;
    logic [mpb_pkg::C_CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mpb_step.sv
// ----------------------------------------------------------------------------
// mpb_step
// Next-state and command logic for one step: read check, pattern or
// generator data, and sweep / pass / phase advance.
// ----------------------------------------------------------------------------
module mpb_step (
    input  mpb_pkg::t_state               i_state,
    input  mpb_pkg::t_cfg                 i_cfg,
    input  logic                          i_func,
    input  logic [mpb_pkg::C_DATA_W-1:0]  i_read_data,
    output mpb_pkg::t_state               o_state,
    output mpb_pkg::t_result              o_result
);
    import mpb_pkg::*;

    localparam t_mat   C_M1    = f_draw_mat(C_DRAW_LEN);
    localparam t_mat   C_M2    = f_draw_mat(2 * C_DRAW_LEN);
    localparam t_words C_WORDS = {f_words(3), f_words(2), f_words(1), f_words(0)};

    t_state              s;
    t_state              n;
    t_result             res;
    logic [C_DATA_W-1:0] mask;
    logic [C_DATA_W-1:0] data;
    logic [31:0]         draw_hi;
    logic [31:0]         draw_lo;
    logic [20:0]         wc_inc;
    logic [4:0]          pc_inc;

    always_comb begin
        mask    = f_mask(i_cfg.word_width_mode);
        s       = i_state;
        if (!i_func) begin
            s.lfsr     = C_SEED;
            s.phase    = PH_ADDR;
            s.pat_idx  = '0;
            s.pass_cnt = '0;
            s.word_cnt = '0;
            s.expected = '0;
            s.pending  = 1'b0;
            s.status   = ST_RUN;
        end else if (i_state.pending) begin
            s.pending = 1'b0;
            if ((i_read_data & mask) != (i_state.expected & mask)) begin
                s.status = ST_FAIL;
            end
        end

        draw_hi = f_mat_mul(C_M1, s.lfsr);
        draw_lo = f_mat_mul(C_M2, s.lfsr);
        wc_inc  = {1'b0, s.word_cnt} + 21'd1;
        pc_inc  = {1'b0, s.pass_cnt} + 5'd1;
        data    = '0;
        n       = s;
        res     = '{command: CMD_IDLE, word_address: '0, write_data: '0,
                    test_phase: s.phase};

        case (s.status)
            ST_RUN: begin
                case (s.phase)
                    PH_ADDR:  data = f_pattern(s.word_cnt[3:0]);
                    PH_SOLID: data = f_pattern(s.pat_idx);
                    default: begin
                        if (i_cfg.word_width_mode == MODE_W64) begin
                            data   = {draw_hi, draw_lo};
                            n.lfsr = draw_lo;
                        end else begin
                            data   = {32'd0, draw_hi};
                            n.lfsr = draw_hi;
                        end
                    end
                endcase
                data = data & mask;
                if (s.pass_cnt == '0) begin
                    res.command = CMD_WRITE;
                    n.pending   = 1'b0;
                end else begin
                    res.command = CMD_READ;
                    n.expected  = data;
                    n.pending   = 1'b1;
                end
                res.word_address = s.word_cnt;
                res.write_data   = data;

                if (wc_inc < C_WORDS[i_cfg.word_width_mode]) begin
                    n.word_cnt = wc_inc[C_ADDR_W-1:0];
                end else begin
                    n.word_cnt = '0;
                    n.lfsr     = C_SEED;
                    if (pc_inc <= {1'b0, i_cfg.read_passes}) begin
                        n.pass_cnt = pc_inc[3:0];
                    end else begin
                        n.pass_cnt = '0;
                        case (s.phase)
                            PH_ADDR: begin
                                n.phase   = PH_SOLID;
                                n.pat_idx = '0;
                            end
                            PH_SOLID: begin
                                if (s.pat_idx != C_PAT_LAST) begin
                                    n.pat_idx = s.pat_idx + 4'd1;
                                end else begin
                                    n.phase = PH_RAND;
                                end
                            end
                            default: n.status = ST_PASS;
                        endcase
                    end
                end
            end
            ST_PASS: res.command = CMD_PASS;
            ST_FAIL: res.command = CMD_FAIL;
            default: res.command = CMD_IDLE;
        endcase

        o_state  = n;
        o_result = res;
    end

endmodule

FILE: rtl/memory_pattern_bist_sequencer.sv
// flow: a step is accepted into the input register, its command is computed from
//   that register, and the command is loaded into the output register once that
//   register is empty or being taken
// throughput: one step per cycle while the output is not stalled, set by the combinational step logic
// reset: synchronous; test state and configuration return to their reset values
//   and valid flags clear at once
// ----------------------------------------------------------------------------
// memory_pattern_bist_sequencer
// Memory self-test sequencer issuing one write, read, pass, fail or idle command
// per step over address, solid and pseudo-random pattern phases.
// ----------------------------------------------------------------------------
module memory_pattern_bist_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpb_in_if.sink     i_in,
    mpb_out_if.source  o_out,
    mpb_cfg_if.sink    i_cfg
);
    import mpb_pkg::*;

    logic                r_in_v;
    logic                r_in_func;
    logic [C_DATA_W-1:0] r_in_data;
    logic                r_out_v;
    t_result             r_res;
    t_state              r_st;
    t_cfg                r_cfg;

    t_state              n_st;
    t_result             n_res;
    logic                s1_fire;

    mpb_step u_step (
        .i_state     (r_st),
        .i_cfg       (r_cfg),
        .i_func      (r_in_func),
        .i_read_data (r_in_data),
        .o_state     (n_st),
        .o_result    (n_res)
    );

    always_comb begin
        s1_fire            = r_in_v && (!r_out_v || o_out.ready);
        i_in.ready         = !r_in_v || s1_fire;
        i_cfg.ready        = 1'b1;
        o_out.valid        = r_out_v;
        o_out.command      = r_res.command;
        o_out.word_address = r_res.word_address;
        o_out.write_data   = r_res.write_data;
        o_out.test_phase   = r_res.test_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_cfg   <= '{word_width_mode: C_MODE_RST, read_passes: C_PASSES_RST};
            r_st    <= '{lfsr: C_SEED, phase: PH_ADDR, pat_idx: '0, pass_cnt: '0,
                         word_cnt: '0, expected: '0, pending: 1'b0, status: ST_IDLE};
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_v <= 1'b1;
            end else if (s1_fire) begin
                r_in_v <= 1'b0;
            end
            if (s1_fire) begin
                r_out_v <= 1'b1;
                r_st    <= n_st;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_WIDTH_MODE:  r_cfg.word_width_mode <= i_cfg.data[1:0];
                    REG_READ_PASSES: r_cfg.read_passes     <= i_cfg.data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_func <= i_in.func;
            r_in_data <= i_in.read_data;
        end
        if (s1_fire) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTH
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.status == ST_FAIL && !(s1_fire && !r_in_func))
        |=> r_st.status == ST_FAIL)
        else $error("failed status left without a start");

    a_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && n_res.command == CMD_READ) |=> r_st.pending)
        else $error("read issued without pending check");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.lfsr != '0)
        else $error("generator reached zero");

    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_v)
        else $error("accepted step not captured");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_v)
        else $error("computed step produced no result");
`endif

endmodule

FILE: tb/tb_memory_pattern_bist_sequencer.sv
// ----------------------------------------------------------------------------
// tb_memory_pattern_bist_sequencer
// Self-checking bench for the memory self-test sequencer. A scoreboard object
// predicts each command from the accepted step transactions and register
// writes. It checks every returned command field by field. Stimulus covers
// idle steps, restarts and short random test runs under changing settings.
// ----------------------------------------------------------------------------
module tb_memory_pattern_bist_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import mpb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DIRECTED_ITEMS = 22;
    localparam int unsigned RANDOM_ITEMS   = 928;
    localparam int unsigned MAX_PRINTS     = 40;

    class bist_scoreboard;
        logic [1:0]  width_mode;
        logic [3:0]  read_passes;
        logic [31:0] lfsr;
        logic [1:0]  phase;
        logic [3:0]  pat_idx;
        int unsigned pass_cnt;
        int unsigned word_cnt;
        logic [63:0] expected;
        bit          read_pending;
        logic [1:0]  status;
        logic [3:0]  nibble_seq [16];
        t_result     cmd_expected [$];
        int unsigned errors;

        function new();
            nibble_seq = '{4'h0, 4'hF, 4'h5, 4'hA, 4'h1, 4'h2, 4'h4, 4'h8,
                           4'h3, 4'h6, 4'h9, 4'hC, 4'h7, 4'hB, 4'hD, 4'hE};
            width_mode   = MODE_W64;
            read_passes  = 4'd4;
            lfsr         = C_SEED;
            phase        = PH_ADDR;
            pat_idx      = '0;
            pass_cnt     = 0;
            word_cnt     = 0;
            expected     = '0;
            read_pending = 1'b0;
            status       = ST_IDLE;
            errors       = 0;
        endfunction

        function logic [63:0] width_mask();
            case (width_mode)
                MODE_W8:  return 64'h0000_0000_0000_00FF;
                MODE_W16: return 64'h0000_0000_0000_FFFF;
                MODE_W32: return 64'h0000_0000_FFFF_FFFF;
                default:  return '1;
            endcase
        endfunction

        function int unsigned sweep_words();
            longint unsigned w;
            w = C_MEM_BYTES >> width_mode;
            if (w > C_MAX_WORDS) begin
                w = C_MAX_WORDS;
            end
            if (w == 0) begin
                w = 1;
            end
            return int'(w);
        endfunction

        function logic [63:0] solid_word(input logic [3:0] idx);
            return {16{nibble_seq[idx]}};
        endfunction

        function logic [31:0] next_random();
            logic [31:0] a;
            logic [31:0] b;
            a = lfsr;
            for (int n = 0; n < C_DRAW_LEN; n++) begin
                b = a;
                a = a + a;
                if (a <= b) begin
                    a = a ^ C_TAP;
                end
            end
            lfsr = a;
            return a;
        endfunction

        function void end_of_access();
            word_cnt++;
            if (word_cnt < sweep_words()) begin
                return;
            end
            word_cnt = 0;
            lfsr     = C_SEED;
            pass_cnt++;
            if (pass_cnt <= read_passes) begin
                return;
            end
            pass_cnt = 0;
            if (phase == PH_ADDR) begin
                phase   = PH_SOLID;
                pat_idx = '0;
            end else if (phase == PH_SOLID) begin
                if (pat_idx < C_PAT_LAST) begin
                    pat_idx++;
                end else begin
                    phase = PH_RAND;
                end
            end else begin
                status = ST_PASS;
            end
        endfunction

        function t_result issue_access();
            t_result     r;
            logic [63:0] data;
            if (phase == PH_ADDR) begin
                data = solid_word(word_cnt[3:0]);
            end else if (phase == PH_SOLID) begin
                data = solid_word(pat_idx);
            end else if (width_mode == MODE_W64) begin
                data[63:32] = next_random();
                data[31:0]  = next_random();
            end else begin
                data = {32'd0, next_random()};
            end
            data = data & width_mask();
            if (pass_cnt == 0) begin
                r.command    = CMD_WRITE;
                read_pending = 1'b0;
            end else begin
                r.command    = CMD_READ;
                expected     = data;
                read_pending = 1'b1;
            end
            r.word_address = word_cnt[19:0];
            r.write_data   = data;
            r.test_phase   = phase;
            end_of_access();
            return r;
        endfunction

        function t_result status_result(input logic [2:0] cmd);
            t_result r;
            r.command      = cmd;
            r.word_address = '0;
            r.write_data   = '0;
            r.test_phase   = phase;
            return r;
        endfunction

        function void apply_reg(input logic [C_CFG_IDX_W-1:0] idx,
                                input logic [C_CFG_DAT_W-1:0] val);
            if (idx == REG_WIDTH_MODE) begin
                width_mode = val[1:0];
            end else if (idx == REG_READ_PASSES) begin
                read_passes = val[3:0];
            end
        endfunction

        function void note_input(input logic f, input logic [63:0] d);
            t_result r;
            if (!f) begin
                lfsr         = C_SEED;
                phase        = PH_ADDR;
                pat_idx      = '0;
                pass_cnt     = 0;
                word_cnt     = 0;
                expected     = '0;
                read_pending = 1'b0;
                status       = ST_RUN;
                r = issue_access();
            end else begin
                if (read_pending) begin
                    read_pending = 1'b0;
                    if ((d & width_mask()) != (expected & width_mask())) begin
                        status = ST_FAIL;
                    end
                end
                case (status)
                    ST_RUN:  r = issue_access();
                    ST_PASS: r = status_result(CMD_PASS);
                    ST_FAIL: r = status_result(CMD_FAIL);
                    default: r = status_result(CMD_IDLE);
                endcase
            end
            cmd_expected.push_back(r);
        endfunction

        function int unsigned pending_count();
            return cmd_expected.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check(input t_result got);
            t_result want;
            if (cmd_expected.size() == 0) begin
                report($sformatf("command %0d with no transaction pending", got.command));
                return;
            end
            want = cmd_expected.pop_front();
            if (got.command !== want.command) begin
                report($sformatf("command %0d, want %0d", got.command, want.command));
            end
            if (got.word_address !== want.word_address) begin
                report($sformatf("address %0h, want %0h", got.word_address,
                                 want.word_address));
            end
            if (got.write_data !== want.write_data) begin
                report($sformatf("data %0h, want %0h", got.write_data, want.write_data));
            end
            if (got.test_phase !== want.test_phase) begin
                report($sformatf("phase %0d, want %0d", got.test_phase, want.test_phase));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    mpb_in_if  in_if ();
    mpb_out_if out_if ();
    mpb_cfg_if cfg_if ();

    memory_pattern_bist_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    bist_scoreboard sb;
    int             idle_level;
    int unsigned    items;
    int unsigned    out_stall;
    int unsigned    quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 999);
        if (idle_level == 0) begin
            return 0;
        end
        if (idle_level == 1) begin
            return (r < 5) ? $urandom_range(1, 20) : 0;
        end
        if (r < 650) begin
            return 0;
        end
        if (r < 940) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // reply to a pending read: exact in the compared bits, noise above them
    function automatic logic [63:0] read_reply(input bit exact);
        logic [63:0] noise;
        logic [63:0] m;
        noise = {$urandom, $urandom};
        if (!sb.read_pending || !exact) begin
            return noise;
        end
        m = sb.width_mask();
        return (noise & ~m) | (sb.expected & m);
    endfunction

    task automatic send_step(input logic f, input logic [63:0] d);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.func      <= f;
        in_if.read_data <= d;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        items++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_count() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [C_CFG_IDX_W-1:0] idx,
                                  input logic [C_CFG_DAT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // result sink with random back-pressure
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_stall = gap_len();
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.command      = out_if.command;
                got.word_address = out_if.word_address;
                got.write_data   = out_if.write_data;
                got.test_phase   = out_if.test_phase;
                sb.check(got);
                moved = 1'b1;
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                sb.note_input(in_if.func, in_if.read_data);
                moved = 1'b1;
            end
            if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
                sb.apply_reg(cfg_if.index, cfg_if.data);
                moved = 1'b1;
            end
        end
        if (moved) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [1:0]  mode_seq [4];
        int unsigned pass_seq [4];
        logic [1:0]  mode;
        int unsigned passes;
        int unsigned sel;
        int unsigned len;

        sb               = new();
        idle_level       = 0;
        items            = 0;
        out_stall        = 0;
        quiet_cycles     = 0;
        mode_seq         = '{MODE_W8, MODE_W64, MODE_W16, MODE_W32};
        pass_seq         = '{1, 15, 0, 4};
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.func       = 1'b1;
        in_if.read_data  = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle steps, then the address pattern across the whole nibble table
        send_step(1'b1, '0);
        send_step(1'b1, '1);
        send_step(1'b0, '1);
        repeat (15) send_step(1'b1, {$urandom, $urandom});
        // restart during a test
        send_step(1'b0, '0);
        repeat (3) send_step(1'b1, '1);

        sel = 0;
        while (items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            drain();
            if (sel < 4) begin
                mode   = mode_seq[sel];
                passes = pass_seq[sel];
            end else begin
                mode   = 2'($urandom_range(0, 3));
                passes = $urandom_range(0, 15);
            end
            sel++;
            if ($urandom_range(0, 3) == 0) begin
                write_register(4'($urandom_range(2, 15)), 8'($urandom_range(0, 255)));
            end
            write_register(REG_WIDTH_MODE, {6'($urandom_range(0, 63)), mode});
            write_register(REG_READ_PASSES, {4'($urandom_range(0, 15)), 4'(passes)});
            idle_level = ($urandom_range(0, 2) == 0) ? 0 : 2;
            len = $urandom_range(5, 60);
            if ($urandom_range(0, 4) != 0) begin
                send_step(1'b0, {$urandom, $urandom});
            end
            for (int k = 0; k < len; k++) begin
                if (k == len / 2 && $urandom_range(0, 5) == 0) begin
                    drain();
                end
                send_step(($urandom_range(0, 29) == 0) ? 1'b0 : 1'b1, read_reply(1'b1));
            end
        end

        in_if.valid <= 1'b0;
        while (sb.pending_count() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: memory_pattern_bist_sequencer.f
rtl/mpb_pkg.sv
rtl/mpb_intf.sv
rtl/mpb_step.sv
rtl/memory_pattern_bist_sequencer.sv
tb/tb_memory_pattern_bist_sequencer.sv
